/* src/assert_macros.svh */
// Assertion helpers used by the queue module.
// Both macros expect i_clk and i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PS2KC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define PS2KC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ps2kc_pkg.sv */
`timescale 1ns / 1ps

package ps2kc_pkg;

    // Operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_KBD_BYTE = 2'd2,
        OP_AUX_BYTE = 2'd3
    } t_op;

    // Target of the next data-port write
    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_CMD     = 2'd1,
        PEND_OUTPORT = 2'd2,
        PEND_AUX     = 2'd3
    } t_pend;

    // Device the written byte is sent toward
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_KBD  = 2'd1,
        TGT_AUX  = 2'd2
    } t_tgt;

    // Source of the read data in the output stage
    typedef enum logic [1:0] {
        RSEL_REG = 2'd0,
        RSEL_KBD = 2'd1,
        RSEL_AUX = 2'd2
    } t_rsel;

    // Port select values
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    // Controller commands
    localparam logic [7:0] CMD_READ_CB   = 8'h20;
    localparam logic [7:0] CMD_WRITE_CB  = 8'h60;
    localparam logic [7:0] CMD_AUX_TEST  = 8'ha9;
    localparam logic [7:0] CMD_AUX_DIS   = 8'ha7;
    localparam logic [7:0] CMD_AUX_EN    = 8'ha8;
    localparam logic [7:0] CMD_SELF_TEST = 8'haa;
    localparam logic [7:0] CMD_KBD_TEST  = 8'hab;
    localparam logic [7:0] CMD_KBD_DIS   = 8'had;
    localparam logic [7:0] CMD_KBD_EN    = 8'hae;
    localparam logic [7:0] CMD_READ_OP   = 8'hd0;
    localparam logic [7:0] CMD_WRITE_OP  = 8'hd1;
    localparam logic [7:0] CMD_WRITE_AUX = 8'hd4;
    localparam logic [7:0] CMD_OP_LO     = 8'hf0;
    localparam logic [7:0] CMD_OP_HI     = 8'hfd;
    localparam logic [7:0] CMD_PULSE     = 8'hfe;

    // Response bytes and masks
    localparam logic [7:0] SELF_TEST_OK = 8'h55;
    localparam logic [7:0] TEST_OK      = 8'h00;
    localparam logic [7:0] OP_KEEP_MASK = 8'h0d;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0f;

    // Reset values
    localparam logic [7:0] CB_RESET = 8'h47;
    localparam logic [7:0] OP_RESET = 8'h02;

    // Command byte bit positions
    localparam int CB_KBD_IRQ = 0;
    localparam int CB_AUX_IRQ = 1;
    localparam int CB_SYS     = 2;
    localparam int CB_KBD_DIS = 4;
    localparam int CB_AUX_DIS = 5;
    localparam int CB_XLATE   = 6;

    // Output port bit carrying the A20 gate
    localparam int OP_A20 = 1;

    typedef struct packed {
        logic [1:0] operation;
        logic       port_select;
        logic [7:0] data_in;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_keyboard;
        logic       irq_auxiliary;
        logic       a20_gate;
        logic       translate_enable;
        logic [1:0] device_target;
        logic [7:0] device_byte;
        logic       reset_pulse;
    } t_out;

    // Queue request from the controller
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_qreq;

    // Queue occupancy seen by the controller
    typedef struct packed {
        logic empty;
        logic single;
        logic full;
    } t_qstat;

endpackage

/* src/ps2kc_ram.sv */
`timescale 1ns / 1ps

module ps2kc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ps2kc_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2kc_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ps2kc_pkg::t_qreq  i_req,
    output ps2kc_pkg::t_qstat o_stat,
    output logic [7:0]        o_rdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;

    // Advance a pointer with wrap at the queue depth
    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    // Occupancy flags from the pointers
    assign o_stat.empty  = (r_tail == r_head);
    assign o_stat.single = (r_tail == f_next(r_head));
    assign o_stat.full   = (f_next(r_tail) == r_head);

    // Advance pointers on push and pop
    always_comb begin
        n_head = i_req.pop  ? f_next(r_head) : r_head;
        n_tail = i_req.push ? f_next(r_tail) : r_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // Byte storage: push writes at the tail, pop reads at the head
    ps2kc_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.push),
        .i_waddr (r_tail),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.pop),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    `PS2KC_ASSERT_IMPL(a_no_push_full, i_req.push, !o_stat.full, "push into a full queue")
    `PS2KC_ASSERT_IMPL(a_no_pop_empty, i_req.pop, !o_stat.empty, "pop from an empty queue")
    `PS2KC_ASSERT(a_ptr_range, (r_head < PW'(QUEUE_DEPTH - 1) || r_head == PW'(QUEUE_DEPTH - 1)) && (r_tail < PW'(QUEUE_DEPTH - 1) || r_tail == PW'(QUEUE_DEPTH - 1)), "queue pointer beyond depth")

endmodule

/* src/ps2kc_ctrl.sv */
`timescale 1ns / 1ps

module ps2kc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ps2kc_pkg::t_in     i_item,
    input  ps2kc_pkg::t_qstat  i_kq,
    input  ps2kc_pkg::t_qstat  i_aq,
    output ps2kc_pkg::t_qreq   o_kreq,
    output ps2kc_pkg::t_qreq   o_areq,
    output ps2kc_pkg::t_out    o_res,
    output ps2kc_pkg::t_rsel   o_rsel
);

    logic [7:0]       r_ctl_byte;
    logic [7:0]       r_out_port;
    logic [7:0]       r_last_wr;
    ps2kc_pkg::t_pend r_pend;

    logic [7:0]       n_ctl_byte;
    logic [7:0]       n_out_port;
    logic [7:0]       n_last_wr;
    ps2kc_pkg::t_pend n_pend;

    ps2kc_pkg::t_qreq kreq;
    ps2kc_pkg::t_qreq areq;
    ps2kc_pkg::t_tgt  tgt;
    logic [7:0]       rbyte;
    logic [7:0]       dbyte;
    logic [7:0]       status;
    logic             pulse;
    logic             k_ne;
    logic             a_ne;
    logic [7:0]       d;

    assign d = i_item.data_in;

    // Status byte from the state before this transaction
    always_comb begin
        status                   = '0;
        status[0]                = !i_kq.empty || !i_aq.empty;
        status[ps2kc_pkg::CB_SYS] = r_ctl_byte[ps2kc_pkg::CB_SYS];
        status[3]                = 1'b1;  // a status read always marks the command port
        status[5]                = i_kq.empty && !i_aq.empty;
    end

    // Decode the transaction and form the next state
    always_comb begin
        n_ctl_byte = r_ctl_byte;
        n_out_port = r_out_port;
        n_last_wr  = r_last_wr;
        n_pend     = r_pend;
        kreq       = '0;
        areq       = '0;
        tgt        = ps2kc_pkg::TGT_NONE;
        rbyte      = '0;
        dbyte      = '0;
        pulse      = 1'b0;
        o_rsel     = ps2kc_pkg::RSEL_REG;
        kreq.wdata = d;
        areq.wdata = d;

        case (ps2kc_pkg::t_op'(i_item.operation))
            ps2kc_pkg::OP_READ: begin
                if (i_item.port_select == ps2kc_pkg::PORT_CMD) begin
                    rbyte = status;
                end else if (!i_kq.empty) begin
                    kreq.pop = 1'b1;
                    o_rsel   = ps2kc_pkg::RSEL_KBD;
                end else if (!i_aq.empty) begin
                    areq.pop = 1'b1;
                    o_rsel   = ps2kc_pkg::RSEL_AUX;
                end else begin
                    rbyte = r_last_wr;
                end
            end
            ps2kc_pkg::OP_WRITE: begin
                if (i_item.port_select == ps2kc_pkg::PORT_CMD) begin
                    case (d)
                        ps2kc_pkg::CMD_READ_CB: begin
                            kreq.push  = !i_kq.full;
                            kreq.wdata = r_ctl_byte;
                        end
                        ps2kc_pkg::CMD_WRITE_CB:  n_pend = ps2kc_pkg::PEND_CMD;
                        ps2kc_pkg::CMD_READ_OP: begin
                            kreq.push  = !i_kq.full;
                            kreq.wdata = r_out_port;
                        end
                        ps2kc_pkg::CMD_WRITE_OP:  n_pend = ps2kc_pkg::PEND_OUTPORT;
                        ps2kc_pkg::CMD_SELF_TEST: begin
                            kreq.push  = !i_kq.full;
                            kreq.wdata = ps2kc_pkg::SELF_TEST_OK;
                        end
                        ps2kc_pkg::CMD_KBD_TEST, ps2kc_pkg::CMD_AUX_TEST: begin
                            kreq.push  = !i_kq.full;
                            kreq.wdata = ps2kc_pkg::TEST_OK;
                        end
                        ps2kc_pkg::CMD_KBD_DIS:
                            n_ctl_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b1;
                        ps2kc_pkg::CMD_KBD_EN:
                            n_ctl_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b0;
                        ps2kc_pkg::CMD_AUX_DIS:
                            n_ctl_byte[ps2kc_pkg::CB_AUX_DIS] = 1'b1;
                        ps2kc_pkg::CMD_AUX_EN:
                            n_ctl_byte[ps2kc_pkg::CB_AUX_DIS] = 1'b0;
                        ps2kc_pkg::CMD_WRITE_AUX: n_pend = ps2kc_pkg::PEND_AUX;
                        ps2kc_pkg::CMD_PULSE:     pulse  = 1'b1;
                        default: begin
                            // OR the command's low nibble into the port, bit 1 replaced, high nibble cleared
                            if (d inside {[ps2kc_pkg::CMD_OP_LO:ps2kc_pkg::CMD_OP_HI]}) begin
                                n_out_port = (r_out_port & ps2kc_pkg::OP_KEEP_MASK)
                                           | (d & ps2kc_pkg::NIBBLE_MASK);
                            end
                        end
                    endcase
                end else begin
                    case (r_pend)
                        ps2kc_pkg::PEND_CMD:     n_ctl_byte = d;
                        ps2kc_pkg::PEND_OUTPORT: n_out_port = d;
                        ps2kc_pkg::PEND_AUX: begin
                            if (!r_ctl_byte[ps2kc_pkg::CB_AUX_DIS]) begin
                                tgt   = ps2kc_pkg::TGT_AUX;
                                dbyte = d;
                            end
                        end
                        default: begin
                            n_last_wr = d;
                            tgt       = ps2kc_pkg::TGT_KBD;
                            dbyte     = d;
                        end
                    endcase
                    n_pend = ps2kc_pkg::PEND_NONE;
                end
            end
            ps2kc_pkg::OP_KBD_BYTE: begin
                kreq.push = !i_kq.full;
            end
            ps2kc_pkg::OP_AUX_BYTE: begin
                areq.push = !i_aq.full && !r_ctl_byte[ps2kc_pkg::CB_AUX_DIS];
            end
            default: ;
        endcase
    end

    // Drive queue requests only for an accepted transaction
    always_comb begin
        o_kreq      = kreq;
        o_areq      = areq;
        o_kreq.push = kreq.push && i_accept;
        o_kreq.pop  = kreq.pop  && i_accept;
        o_areq.push = areq.push && i_accept;
        o_areq.pop  = areq.pop  && i_accept;
    end

    // Queue occupancy after this transaction
    assign k_ne = kreq.push || (!i_kq.empty && !(kreq.pop && i_kq.single));
    assign a_ne = areq.push || (!i_aq.empty && !(areq.pop && i_aq.single));

    // Form the result fields
    always_comb begin
        o_res                  = '0;
        o_res.read_data        = rbyte;
        o_res.a20_gate         = n_out_port[ps2kc_pkg::OP_A20];
        o_res.translate_enable = n_ctl_byte[ps2kc_pkg::CB_XLATE];
        o_res.device_target    = tgt;
        o_res.device_byte      = dbyte;
        o_res.reset_pulse      = pulse;
        if (k_ne) begin
            o_res.irq_keyboard = n_ctl_byte[ps2kc_pkg::CB_KBD_IRQ]
                              && !n_ctl_byte[ps2kc_pkg::CB_KBD_DIS];
        end else if (a_ne) begin
            o_res.irq_auxiliary = n_ctl_byte[ps2kc_pkg::CB_AUX_IRQ];
        end
    end

    // Hold controller state, update on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_byte <= ps2kc_pkg::CB_RESET;
            r_out_port <= ps2kc_pkg::OP_RESET;
            r_last_wr  <= '0;
            r_pend     <= ps2kc_pkg::PEND_NONE;
        end else if (i_accept) begin
            r_ctl_byte <= n_ctl_byte;
            r_out_port <= n_out_port;
            r_last_wr  <= n_last_wr;
            r_pend     <= n_pend;
        end
    end

endmodule

/* src/ps2_keyboard_controller_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in  (ps2kc_pkg::t_in)
// result    out        o_out_valid / i_out_ready   o_out (ps2kc_pkg::t_out)
//
// One transaction per cycle unless the result stalls; a result is
// registered, output the cycle after its input. Queue reads are registered;
// a data read pops on accept and its byte shows up with the result register.
// Reset is synchronous and active low; queues start empty, no clearing pass.
// A stalled result holds; input is taken in the same cycle the result leaves.

module ps2_keyboard_controller_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ps2kc_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ps2kc_pkg::t_out o_out
);

    logic              accept;
    ps2kc_pkg::t_qreq  kreq;
    ps2kc_pkg::t_qreq  areq;
    ps2kc_pkg::t_qstat kstat;
    ps2kc_pkg::t_qstat astat;
    logic [7:0]        k_rdata;
    logic [7:0]        a_rdata;
    ps2kc_pkg::t_out   res;
    ps2kc_pkg::t_rsel  rsel;

    logic              r_out_valid;
    ps2kc_pkg::t_out   r_res;
    ps2kc_pkg::t_rsel  r_rsel;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    ps2kc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .i_kq     (kstat),
        .i_aq     (astat),
        .o_kreq   (kreq),
        .o_areq   (areq),
        .o_res    (res),
        .o_rsel   (rsel)
    );

    ps2kc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_kbd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (kreq),
        .o_stat  (kstat),
        .o_rdata (k_rdata)
    );

    ps2kc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_aux_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (areq),
        .o_stat  (astat),
        .o_rdata (a_rdata)
    );

    // Result valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= accept || (r_out_valid && !i_out_ready);
        end
    end

    // Result payload and read source
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res  <= res;
            r_rsel <= rsel;
        end
    end

    // Pick read data from the queue memory or the registered byte
    always_comb begin
        o_out = r_res;
        case (r_rsel)
            ps2kc_pkg::RSEL_KBD: o_out.read_data = k_rdata;
            ps2kc_pkg::RSEL_AUX: o_out.read_data = a_rdata;
            default:             o_out.read_data = r_res.read_data;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sim/ps2_keyboard_controller_unit_tb.sv */
`timescale 1ns / 1ps

// Usable slots per device queue: one slot of the ring stays empty
localparam int FIFO_USABLE = 15;

// Status byte bit positions
localparam int ST_OBF = 0;
localparam int ST_SYS = 2;
localparam int ST_CMD = 3;
localparam int ST_AUX = 5;

class kbc_scoreboard;
    logic [7:0]         kbd_fifo[$];
    logic [7:0]         aux_fifo[$];
    logic [7:0]         ctl_byte;
    logic [7:0]         out_port;
    logic [7:0]         last_data_written;
    ps2kc_pkg::t_pend   write_target;
    logic               last_was_cmd;
    ps2kc_pkg::t_out    expected_results[$];
    int                 mismatches;

    function new();
        ctl_byte          = ps2kc_pkg::CB_RESET;
        out_port          = ps2kc_pkg::OP_RESET;
        last_data_written = '0;
        write_target      = ps2kc_pkg::PEND_NONE;
        last_was_cmd      = 1'b0;
        mismatches        = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Queue a byte toward the host; drop it when the keyboard queue is full
    function void queue_reply(logic [7:0] b);
        if (kbd_fifo.size() < FIFO_USABLE) begin
            kbd_fifo.push_back(b);
        end
    endfunction

    // Advance the controller state by one input transaction and record the result
    function void note_transaction(ps2kc_pkg::t_in txn);
        ps2kc_pkg::t_out r;
        logic [7:0]      d;
        r = '0;
        d = txn.data_in;
        case (ps2kc_pkg::t_op'(txn.operation))
            ps2kc_pkg::OP_READ: begin
                if (txn.port_select == ps2kc_pkg::PORT_CMD) begin
                    last_was_cmd        = 1'b1;
                    r.read_data[ST_OBF] = (kbd_fifo.size() > 0) || (aux_fifo.size() > 0);
                    r.read_data[ST_SYS] = ctl_byte[ps2kc_pkg::CB_SYS];
                    r.read_data[ST_CMD] = last_was_cmd;
                    r.read_data[ST_AUX] = (kbd_fifo.size() == 0) && (aux_fifo.size() > 0);
                end else begin
                    last_was_cmd = 1'b0;
                    if (kbd_fifo.size() > 0) begin
                        r.read_data = kbd_fifo.pop_front();
                    end else if (aux_fifo.size() > 0) begin
                        r.read_data = aux_fifo.pop_front();
                    end else begin
                        r.read_data = last_data_written;
                    end
                end
            end
            ps2kc_pkg::OP_WRITE: begin
                if (txn.port_select == ps2kc_pkg::PORT_CMD) begin
                    last_was_cmd = 1'b1;
                    case (d)
                        ps2kc_pkg::CMD_READ_CB:   queue_reply(ctl_byte);
                        ps2kc_pkg::CMD_WRITE_CB:  write_target = ps2kc_pkg::PEND_CMD;
                        ps2kc_pkg::CMD_READ_OP:   queue_reply(out_port);
                        ps2kc_pkg::CMD_WRITE_OP:  write_target = ps2kc_pkg::PEND_OUTPORT;
                        ps2kc_pkg::CMD_SELF_TEST: queue_reply(ps2kc_pkg::SELF_TEST_OK);
                        ps2kc_pkg::CMD_KBD_TEST:  queue_reply(ps2kc_pkg::TEST_OK);
                        ps2kc_pkg::CMD_AUX_TEST:  queue_reply(ps2kc_pkg::TEST_OK);
                        ps2kc_pkg::CMD_KBD_DIS:   ctl_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b1;
                        ps2kc_pkg::CMD_KBD_EN:    ctl_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b0;
                        ps2kc_pkg::CMD_AUX_DIS:   ctl_byte[ps2kc_pkg::CB_AUX_DIS] = 1'b1;
                        ps2kc_pkg::CMD_AUX_EN:    ctl_byte[ps2kc_pkg::CB_AUX_DIS] = 1'b0;
                        ps2kc_pkg::CMD_WRITE_AUX: write_target = ps2kc_pkg::PEND_AUX;
                        ps2kc_pkg::CMD_PULSE:     r.reset_pulse = 1'b1;
                        default: begin
                            // Output port pulse commands OR in the low nibble, replace bit 1 and clear the high nibble
                            if (d >= ps2kc_pkg::CMD_OP_LO && d <= ps2kc_pkg::CMD_OP_HI) begin
                                out_port = (out_port & ps2kc_pkg::OP_KEEP_MASK)
                                         | (d & ps2kc_pkg::NIBBLE_MASK);
                            end
                        end
                    endcase
                end else begin
                    last_was_cmd = 1'b0;
                    case (write_target)
                        ps2kc_pkg::PEND_CMD:     ctl_byte = d;
                        ps2kc_pkg::PEND_OUTPORT: out_port = d;
                        ps2kc_pkg::PEND_AUX: begin
                            if (!ctl_byte[ps2kc_pkg::CB_AUX_DIS]) begin
                                r.device_target = ps2kc_pkg::TGT_AUX;
                                r.device_byte   = d;
                            end
                        end
                        default: begin
                            last_data_written = d;
                            r.device_target   = ps2kc_pkg::TGT_KBD;
                            r.device_byte     = d;
                        end
                    endcase
                    write_target = ps2kc_pkg::PEND_NONE;
                end
            end
            ps2kc_pkg::OP_KBD_BYTE: queue_reply(d);
            default: begin
                if (!ctl_byte[ps2kc_pkg::CB_AUX_DIS] && aux_fifo.size() < FIFO_USABLE) begin
                    aux_fifo.push_back(d);
                end
            end
        endcase

        // Interrupt levels follow the byte on offer
        if (kbd_fifo.size() > 0) begin
            r.irq_keyboard = ctl_byte[ps2kc_pkg::CB_KBD_IRQ] & ~ctl_byte[ps2kc_pkg::CB_KBD_DIS];
        end else if (aux_fifo.size() > 0) begin
            r.irq_auxiliary = ctl_byte[ps2kc_pkg::CB_AUX_IRQ];
        end
        r.a20_gate         = out_port[ps2kc_pkg::OP_A20];
        r.translate_enable = ctl_byte[ps2kc_pkg::CB_XLATE];
        expected_results.push_back(r);
    endfunction

    // Compare a delivered result with the oldest expectation
    function void check_transaction(ps2kc_pkg::t_out got);
        ps2kc_pkg::t_out exp_r;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result with nothing outstanding: %h", got);
            end
            return;
        end
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp rd=%h irqk=%b irqa=%b a20=%b xlat=%b",
                         exp_r.read_data, exp_r.irq_keyboard, exp_r.irq_auxiliary,
                         exp_r.a20_gate, exp_r.translate_enable);
                $display("          exp tgt=%0d byte=%h rst=%b",
                         exp_r.device_target, exp_r.device_byte, exp_r.reset_pulse);
                $display("          got rd=%h irqk=%b irqa=%b a20=%b xlat=%b",
                         got.read_data, got.irq_keyboard, got.irq_auxiliary,
                         got.a20_gate, got.translate_enable);
                $display("          got tgt=%0d byte=%h rst=%b",
                         got.device_target, got.device_byte, got.reset_pulse);
            end
        end
    endfunction
endclass

module ps2_keyboard_controller_unit_tb;
    localparam int IDLE_PCT     = 38;
    localparam int TOTAL_ITEMS  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_KNOWN    = 13;
    localparam logic [7:0] KNOWN_CMDS [NUM_KNOWN] = '{
        ps2kc_pkg::CMD_READ_CB, ps2kc_pkg::CMD_WRITE_CB, ps2kc_pkg::CMD_AUX_TEST,
        ps2kc_pkg::CMD_AUX_DIS, ps2kc_pkg::CMD_AUX_EN, ps2kc_pkg::CMD_SELF_TEST,
        ps2kc_pkg::CMD_KBD_TEST, ps2kc_pkg::CMD_KBD_DIS, ps2kc_pkg::CMD_KBD_EN,
        ps2kc_pkg::CMD_READ_OP, ps2kc_pkg::CMD_WRITE_OP, ps2kc_pkg::CMD_WRITE_AUX,
        ps2kc_pkg::CMD_PULSE
    };

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            in_valid  = 1'b0;
    logic            out_ready = 1'b0;
    ps2kc_pkg::t_in  in_txn    = '0;
    logic            o_in_ready;
    logic            o_out_valid;
    ps2kc_pkg::t_out o_out;

    kbc_scoreboard sb;
    int    sent_items    = 0;
    bit    calm          = 1'b0;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;
    int    quiet_cycles  = 0;

    ps2_keyboard_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_txn),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Drive result ready: long hold-off on request, always ready when calm, else random back-pressure
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check results, record inputs, and watch for a stuck block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                sb.check_transaction(o_out);
            end
            if (in_valid && o_in_ready) begin
                sb.note_transaction(in_txn);
            end
            if ((o_out_valid && out_ready) || (in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("ps2_keyboard_controller_unit regression: fail");
                $finish;
            end
        end
    end

    // Offer one input transaction, with random idle cycles ahead of it unless calm
    task automatic send(ps2kc_pkg::t_op op, logic port, logic [7:0] data);
        ps2kc_pkg::t_in txn;
        txn.operation   = op;
        txn.port_select = port;
        txn.data_in     = data;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_txn   <= txn;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    // Run of device bytes or port reads with random content
    task automatic burst(ps2kc_pkg::t_op op, int count);
        repeat (count) begin
            if (op == ps2kc_pkg::OP_READ) begin
                send(op, ($urandom_range(99) < 20) ? ps2kc_pkg::PORT_CMD : ps2kc_pkg::PORT_DATA,
                     8'($urandom_range(255)));
            end else begin
                send(op, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Controller command, followed by its data byte most of the time if it takes one, or a lone data write
    task automatic random_command();
        int         k;
        logic [7:0] c;
        k = $urandom_range(99);
        if (k < 60) begin
            c = KNOWN_CMDS[$urandom_range(NUM_KNOWN - 1)];
        end else if (k < 70) begin
            c = 8'($urandom_range(ps2kc_pkg::CMD_OP_HI, ps2kc_pkg::CMD_OP_LO));
        end else if (k < 85) begin
            c = 8'($urandom_range(255));
        end else begin
            send(ps2kc_pkg::OP_WRITE, ps2kc_pkg::PORT_DATA, 8'($urandom_range(255)));
            return;
        end
        send(ps2kc_pkg::OP_WRITE, ps2kc_pkg::PORT_CMD, c);
        if ((c == ps2kc_pkg::CMD_WRITE_CB || c == ps2kc_pkg::CMD_WRITE_OP
                || c == ps2kc_pkg::CMD_WRITE_AUX) && $urandom_range(99) < 85) begin
            send(ps2kc_pkg::OP_WRITE, ps2kc_pkg::PORT_DATA, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int pick;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reads from an empty controller, then a keyboard write and its echo
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_CMD,  8'h00);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_DATA, 8'hff);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_DATA, 8'hff);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_DATA, 8'h00);
        // Device bytes ignore port select; keyboard wins over aux
        send(ps2kc_pkg::OP_KBD_BYTE, ps2kc_pkg::PORT_CMD,  8'h00);
        send(ps2kc_pkg::OP_AUX_BYTE, ps2kc_pkg::PORT_DATA, 8'hff);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_CMD,  8'h00);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_DATA, 8'h00);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_CMD,  8'hff);
        send(ps2kc_pkg::OP_READ,     ps2kc_pkg::PORT_DATA, 8'h00);
        // Aux disabled drops incoming bytes and suppresses aux writes
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_AUX_DIS);
        send(ps2kc_pkg::OP_AUX_BYTE, ps2kc_pkg::PORT_DATA, 8'h3c);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_WRITE_AUX);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_DATA, 8'ha5);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_AUX_EN);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_WRITE_AUX);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_DATA, 8'h5a);
        // Commands that queue a reply, toggle enables, pulse reset, set the output port, or do nothing
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_READ_CB);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_SELF_TEST);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_KBD_TEST);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_AUX_TEST);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_READ_OP);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_KBD_DIS);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_PULSE);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_OP_LO);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  8'h00);
        // A command without a target keeps the pending write target
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_WRITE_CB);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_KBD_EN);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_DATA, 8'h00);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_WRITE_OP);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_DATA, 8'h00);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  ps2kc_pkg::CMD_OP_HI);
        send(ps2kc_pkg::OP_WRITE,    ps2kc_pkg::PORT_CMD,  8'hff);
        // Overfill both queues, then drain them
        burst(ps2kc_pkg::OP_KBD_BYTE, 17);
        burst(ps2kc_pkg::OP_AUX_BYTE, 17);
        burst(ps2kc_pkg::OP_READ, 40);

        // Random sequences: bursts, commands with data, and some noise
        while (sent_items < TOTAL_ITEMS) begin
            calm = (sent_items >= 160 && sent_items < 240);
            if (!hold_done && sent_items >= 270) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            if (!pause_done && sent_items >= 360) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 25) begin
                burst(ps2kc_pkg::OP_KBD_BYTE, $urandom_range(18, 1));
            end else if (pick < 40) begin
                burst(ps2kc_pkg::OP_AUX_BYTE, $urandom_range(18, 1));
            end else if (pick < 65) begin
                burst(ps2kc_pkg::OP_READ, $urandom_range(18, 1));
            end else if (pick < 90) begin
                random_command();
            end else begin
                send(ps2kc_pkg::t_op'($urandom_range(3)), 1'($urandom_range(1)),
                     8'($urandom_range(255)));
            end
        end
        calm = 1'b0;

        // Drain outstanding results, then settle
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ps2_keyboard_controller_unit regression: pass");
        end else begin
            $display("ps2_keyboard_controller_unit regression: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/ps2kc_pkg.sv
src/ps2kc_ram.sv
src/ps2kc_queue.sv
src/ps2kc_ctrl.sv
src/ps2_keyboard_controller_unit.sv
sim/ps2_keyboard_controller_unit_tb.sv
